// File: rtl/core/paired_device_key_store_macros.svh
// Assertion shorthands shared by the key store RTL.
// Each expects clk and arst_n in scope.
`ifndef PAIRED_DEVICE_KEY_STORE_MACROS_SVH
`define PAIRED_DEVICE_KEY_STORE_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define PDKS_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define PDKS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/pdks_pkg.sv
package pdks_pkg;

	localparam int ADDR_W  = 48;
	localparam int KEY_W   = 64;
	localparam int CMD_W   = 2;
	localparam int COUNT_W = 4;

	typedef enum logic [CMD_W-1:0] {
		CMD_SAVE     = 2'd0,
		CMD_LOOKUP   = 2'd1,
		CMD_DELETE   = 2'd2,
		CMD_SET_LAST = 2'd3
	} pdks_cmd_t;

	// one stored pairing: address plus 128-bit link key
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [KEY_W-1:0]  key_high;
		logic [KEY_W-1:0]  key_low;
	} pdks_entry_t;

endpackage

// File: rtl/core/pdks_table.sv
// Entry RAM: one write port, one read port, registered read.
// Per-entry valid flops give the all-zero reset image.
module pdks_table #(
	parameter int ENTRIES = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              rd_en,
	input  logic [$clog2(ENTRIES)-1:0]        rd_addr,
	output pdks_pkg::pdks_entry_t             rd_entry,
	input  logic                              wr_en,
	input  logic [$clog2(ENTRIES)-1:0]        wr_addr,
	input  pdks_pkg::pdks_entry_t             wr_entry
);
	import pdks_pkg::*;

	pdks_entry_t mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	pdks_entry_t rd_data_q;
	logic rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	// never-written slots read as zero
	assign rd_entry = rd_valid_q ? rd_data_q : '0;

endmodule

// File: rtl/core/paired_device_key_store.sv
// Paired device key store. Holds up to ENTRIES device addresses with their
// 128-bit link keys in a single-port-write, registered-read entry RAM and
// runs one command at a time: save, lookup, delete or set-last-connected.
// A command is taken at a clock edge with start high and busy low; busy
// rises the next cycle. done is high for exactly one cycle, with the result
// on the result ports, and the receiver cannot stall it: sample it then
// or lose it. busy is already low in the done cycle, so the next command
// may be issued there. The search reads slots one per cycle, at least one,
// and a delete then moves any used entries above its hit down one per
// cycle. Set-last-connected and any command on an empty table finish at
// the first slot check. The RAM read port sets the pace: the compare of
// one slot overlaps the read of the next. After reset the table reads as
// all zero at once (per-slot valid flops), so there is no clearing pass.
// last_address, last_valid and paired_count show the state after the
// command; the key outputs are zero unless a lookup hits.
`include "paired_device_key_store_macros.svh"

module paired_device_key_store #(
	parameter int ENTRIES = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [pdks_pkg::CMD_W-1:0]      command,
	input  logic [pdks_pkg::ADDR_W-1:0]     device_address,
	input  logic [pdks_pkg::KEY_W-1:0]      key_high,
	input  logic [pdks_pkg::KEY_W-1:0]      key_low,
	output logic                            done,
	output logic                            hit,
	output logic [pdks_pkg::KEY_W-1:0]      found_key_high,
	output logic [pdks_pkg::KEY_W-1:0]      found_key_low,
	output logic [pdks_pkg::ADDR_W-1:0]     last_address,
	output logic                            last_valid,
	output logic [pdks_pkg::COUNT_W-1:0]    paired_count
);
	import pdks_pkg::*;

	localparam int IW = $clog2(ENTRIES);       // slot index
	localparam int CW = $clog2(ENTRIES + 1);   // count, holds ENTRIES itself

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_CHECK = 3'b010,   // compare slot idx, read ahead idx+1
		S_SHIFT = 3'b100    // copy slot idx+1 down into idx
	} state_t;

	state_t state_q, state_d;

	// control state
	logic [IW-1:0]     idx_q, idx_d;
	logic [CW-1:0]     count_q, count_d;
	logic [IW-1:0]     slot_q, slot_d;      // ring slot for new entries
	logic [ADDR_W-1:0] last_q, last_d;
	logic              done_q;

	// latched command
	pdks_cmd_t         cmd_q;
	logic [ADDR_W-1:0] addr_q;
	logic [KEY_W-1:0]  kh_q, kl_q;

	// result
	logic              hit_q;
	logic [KEY_W-1:0]  fkh_q, fkl_q;

	// RAM port
	logic              rd_en, wr_en;
	logic [IW-1:0]     rd_addr, wr_addr;
	pdks_entry_t       rd_entry, wr_entry;

	// decode
	logic              finish, del_done, res_hit;
	logic [KEY_W-1:0]  res_kh, res_kl;
	logic              match, in_range, more_used, more_all, last_used, shift_more;
	logic [CW:0]       idx_w, cnt_w, ent_w, slot_w;
	logic [CW-1:0]     cnt_m1;
	logic [CW+3:0]     count_x;

	pdks_table #(
		.ENTRIES (ENTRIES)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_entry (wr_entry)
	);

	assign idx_w  = (CW+1)'(idx_q);
	assign cnt_w  = (CW+1)'(count_q);
	assign ent_w  = (CW+1)'(ENTRIES);
	assign slot_w = (CW+1)'(slot_q);
	assign cnt_m1 = count_q - CW'(1);

	assign match      = (rd_entry.addr == addr_q);
	assign in_range   = (idx_w < cnt_w);
	assign more_used  = (idx_w + (CW+1)'(1) < cnt_w);
	assign more_all   = (idx_w + (CW+1)'(1) < ent_w);
	assign last_used  = (idx_w + (CW+1)'(1) == cnt_w);
	assign shift_more = (idx_w + (CW+1)'(2) < cnt_w);

	// Reads never target a slot being written in the same cycle: the search
	// writes only when it stops, and the shift reads two slots ahead of its
	// write, so no forwarding path is needed.
	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		count_d  = count_q;
		slot_d   = slot_q;
		last_d   = last_q;
		finish   = 1'b0;
		del_done = 1'b0;
		res_hit  = 1'b0;
		res_kh   = '0;
		res_kl   = '0;
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = idx_q;
		wr_entry = '{addr: addr_q, key_high: kh_q, key_low: kl_q};

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					rd_en   = 1'b1;
					rd_addr = '0;
					idx_d   = '0;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				unique case (cmd_q)
					CMD_SAVE: begin
						last_d = addr_q;
						if (in_range && match) begin
							// refresh key in place
							wr_en   = 1'b1;
							res_hit = 1'b1;
							finish  = 1'b1;
						end else if (more_used) begin
							rd_en   = 1'b1;
							rd_addr = idx_q + IW'(1);
							idx_d   = idx_q + IW'(1);
						end else begin
							// new entry at the ring slot; once full it overwrites what is there
							wr_en   = 1'b1;
							wr_addr = slot_q;
							slot_d  = (slot_w + (CW+1)'(1) >= ent_w) ? '0 : slot_q + IW'(1);
							if (cnt_w < ent_w) begin
								count_d = count_q + CW'(1);
							end
							finish  = 1'b1;
						end
					end
					CMD_LOOKUP: begin
						if (in_range && match) begin
							res_hit = 1'b1;
							res_kh  = rd_entry.key_high;
							res_kl  = rd_entry.key_low;
							finish  = 1'b1;
						end else if (more_used) begin
							rd_en   = 1'b1;
							rd_addr = idx_q + IW'(1);
							idx_d   = idx_q + IW'(1);
						end else begin
							finish  = 1'b1;
						end
					end
					CMD_DELETE: begin
						// search covers every slot, stale ones included
						if (count_q == '0) begin
							finish = 1'b1;
						end else if (match) begin
							if (last_used) begin
								wr_en    = 1'b1;
								wr_entry = '0;
								del_done = 1'b1;
							end else if (more_used) begin
								rd_en   = 1'b1;
								rd_addr = idx_q + IW'(1);
								state_d = S_SHIFT;
							end else begin
								// stale hit above the used range: nothing moves
								del_done = 1'b1;
							end
						end else if (more_all) begin
							rd_en   = 1'b1;
							rd_addr = idx_q + IW'(1);
							idx_d   = idx_q + IW'(1);
						end else begin
							finish = 1'b1;
						end
					end
					CMD_SET_LAST: begin
						last_d = addr_q;
						finish = 1'b1;
					end
					default: begin
						finish = 1'b1;
					end
				endcase
			end
			S_SHIFT: begin
				// old last used slot keeps its contents
				wr_en    = 1'b1;
				wr_entry = rd_entry;
				idx_d    = idx_q + IW'(1);
				if (shift_more) begin
					rd_en   = 1'b1;
					rd_addr = idx_q + IW'(2);
				end else begin
					del_done = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (del_done) begin
			res_hit = 1'b1;
			count_d = cnt_m1;
			slot_d  = cnt_m1[IW-1:0];
			if (last_q == addr_q) begin
				last_d = '0;
			end
			finish  = 1'b1;
		end

		if (finish) begin
			state_d = S_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			count_q <= '0;
			slot_q  <= '0;
			last_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			count_q <= count_d;
			slot_q  <= slot_d;
			last_q  <= last_d;
			done_q  <= finish;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			cmd_q  <= pdks_cmd_t'(command);
			addr_q <= device_address;
			kh_q   <= key_high;
			kl_q   <= key_low;
		end
		if (finish) begin
			hit_q <= res_hit;
			fkh_q <= res_kh;
			fkl_q <= res_kl;
		end
	end

	assign count_x = (CW+4)'(count_q);

	assign busy           = (state_q != S_IDLE);
	assign done           = done_q;
	assign hit            = hit_q;
	assign found_key_high = fkh_q;
	assign found_key_low  = fkl_q;
	assign last_address   = last_q;
	assign last_valid     = (count_q != '0);
	assign paired_count   = count_x[COUNT_W-1:0];

	`PDKS_ASSERT(a_count_bound, count_q <= CW'(ENTRIES), "paired count above table size")
	`PDKS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
	`PDKS_ASSERT(a_count_with_done, $stable(count_q) || done, "count moved without a result")
	`PDKS_ASSERT(a_miss_zero_key, !done || hit || (found_key_high == '0 && found_key_low == '0),
		"key returned without a hit")
	`PDKS_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe held over two cycles")

endmodule

// File: dv/paired_device_key_store_tb.sv
`timescale 1ns / 1ps

module paired_device_key_store_tb;

	import pdks_pkg::*;

	// table size the block is built with; the checker's own table follows it
	localparam int SLOTS        = 8;
	localparam int RANDOM_ITEMS = 1625;
	// last stretch of the random part runs with start held back-to-back
	localparam int QUIET_FROM   = RANDOM_ITEMS - 200;
	localparam int SEGMENT      = 40;
	localparam int POOL_SIZE    = 12;
	// settle margin, well above the slowest command
	localparam int SETTLE       = 4 * SLOTS + 8;

	// what one command reports back
	typedef struct packed {
		logic              hit;
		logic [KEY_W-1:0]  key_hi;
		logic [KEY_W-1:0]  key_lo;
		logic [ADDR_W-1:0] last_addr;
		logic              last_valid;
		logic [COUNT_W-1:0] total;
	} pairing_result_t;

	// one row of the directed table; want is only used where typed is set
	typedef struct {
		pdks_cmd_t         op;
		logic [ADDR_W-1:0] addr;
		logic [KEY_W-1:0]  kh;
		logic [KEY_W-1:0]  kl;
		bit                typed;
		pairing_result_t   want;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [CMD_W-1:0]    command = '0;
	logic [ADDR_W-1:0]   device_address = '0;
	logic [KEY_W-1:0]    key_high = '0;
	logic [KEY_W-1:0]    key_low = '0;
	logic                busy;
	logic                done;
	logic                hit;
	logic [KEY_W-1:0]    found_key_high;
	logic [KEY_W-1:0]    found_key_low;
	logic [ADDR_W-1:0]   last_address;
	logic                last_valid;
	logic [COUNT_W-1:0]  paired_count;

	paired_device_key_store #(
		.ENTRIES(SLOTS)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.command        (command),
		.device_address (device_address),
		.key_high       (key_high),
		.key_low        (key_low),
		.done           (done),
		.hit            (hit),
		.found_key_high (found_key_high),
		.found_key_low  (found_key_low),
		.last_address   (last_address),
		.last_valid     (last_valid),
		.paired_count   (paired_count)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow copy of the pairing table, updated in command order as each
	// item is accepted. Vacated slots keep stale contents just as the block
	// does, since delete searches every slot, used or not.
	// ------------------------------------------------------------------
	logic [ADDR_W-1:0] paired_addr   [SLOTS];
	logic [KEY_W-1:0]  paired_key_hi [SLOTS];
	logic [KEY_W-1:0]  paired_key_lo [SLOTS];
	int                paired_total;
	int                ring_slot;
	logic [ADDR_W-1:0] last_conn;

	pairing_result_t outcomes_due [$];

	// run statistics
	int n_cmd [4];
	int lookup_hits, delete_hits, save_updates, stale_deletes, ring_overwrites;
	int peak_total, empty_returns;
	int accepted, checked, fail_count;

	// first match among the used slots only, -1 if none
	function automatic int used_slot_of(logic [ADDR_W-1:0] addr);
		for (int i = 0; i < paired_total; i++)
			if (paired_addr[i] == addr)
				return i;
		return -1;
	endfunction

	// applies one command to the shadow table and returns what it reports
	function automatic pairing_result_t pairing_outcome(pdks_cmd_t op,
			logic [ADDR_W-1:0] addr, logic [KEY_W-1:0] kh, logic [KEY_W-1:0] kl);
		pairing_result_t r;
		int pos;
		r = '0;
		n_cmd[op]++;
		case (op)
		CMD_SAVE: begin
			last_conn = addr;
			pos = used_slot_of(addr);
			if (pos >= 0) begin
				r.hit = 1'b1;
				save_updates++;
			end else begin
				// new entry goes to the ring slot; once full it overwrites what is there
				pos = ring_slot;
				ring_slot = (ring_slot + 1 >= SLOTS) ? 0 : ring_slot + 1;
				if (paired_total < SLOTS)
					paired_total++;
				else
					ring_overwrites++;
			end
			paired_addr[pos]   = addr;
			paired_key_hi[pos] = kh;
			paired_key_lo[pos] = kl;
		end
		CMD_LOOKUP: begin
			pos = used_slot_of(addr);
			if (pos >= 0) begin
				r.hit    = 1'b1;
				r.key_hi = paired_key_hi[pos];
				r.key_lo = paired_key_lo[pos];
				lookup_hits++;
			end
		end
		CMD_DELETE: begin
			pos = -1;
			if (paired_total != 0)
				for (int i = SLOTS - 1; i >= 0; i--)
					if (paired_addr[i] == addr)
						pos = i;
			if (pos >= 0) begin
				r.hit = 1'b1;
				delete_hits++;
				if (pos >= paired_total)
					stale_deletes++;
				if (pos == paired_total - 1) begin
					paired_addr[pos]   = '0;
					paired_key_hi[pos] = '0;
					paired_key_lo[pos] = '0;
				end else begin
					// compact; the former last used slot keeps its old copy
					for (int i = pos; i + 1 < paired_total; i++) begin
						paired_addr[i]   = paired_addr[i + 1];
						paired_key_hi[i] = paired_key_hi[i + 1];
						paired_key_lo[i] = paired_key_lo[i + 1];
					end
				end
				if (last_conn == addr)
					last_conn = '0;
				paired_total--;
				ring_slot = paired_total;
				if (paired_total == 0)
					empty_returns++;
			end
		end
		default: begin
			last_conn = addr;
		end
		endcase
		if (paired_total > peak_total)
			peak_total = paired_total;
		r.last_addr  = last_conn;
		r.last_valid = (paired_total != 0);
		r.total      = paired_total[COUNT_W-1:0];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Directed table: empty-table lookup and delete, set-last on an empty
	// table, extremes of address and key, save over an existing entry,
	// fill to capacity and wrap the ring, delete in the middle (shift),
	// delete of the last used slot (cleared), delete of the connected
	// device, delete that only finds a stale copy above the count, a miss,
	// and lookups of stale and live entries.
	// ------------------------------------------------------------------
	stim_row_t directed [25] = '{
		'{CMD_LOOKUP, 48'h0, 64'h0, 64'h0, 1'b1,
			'{1'b0, 64'h0, 64'h0, 48'h0, 1'b0, 4'd0}},
		'{CMD_DELETE, 48'h0, '1, '1, 1'b1,
			'{1'b0, 64'h0, 64'h0, 48'h0, 1'b0, 4'd0}},
		'{CMD_SET_LAST, 48'hFFFF_FFFF_FFFF, 64'h0, 64'h0, 1'b1,
			'{1'b0, 64'h0, 64'h0, 48'hFFFF_FFFF_FFFF, 1'b0, 4'd0}},
		'{CMD_SAVE, 48'hFFFF_FFFF_FFFF, '1, '1, 1'b1,
			'{1'b0, 64'h0, 64'h0, 48'hFFFF_FFFF_FFFF, 1'b1, 4'd1}},
		'{CMD_LOOKUP, 48'hFFFF_FFFF_FFFF, 64'h0, 64'h0, 1'b1,
			'{1'b1, '1, '1, 48'hFFFF_FFFF_FFFF, 1'b1, 4'd1}},
		'{CMD_SAVE, 48'h0, 64'h0, 64'h0, 1'b1,
			'{1'b0, 64'h0, 64'h0, 48'h0, 1'b1, 4'd2}},
		'{CMD_SAVE, 48'hFFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
			1'b0, '0},
		'{CMD_SAVE, 48'hAAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
			1'b0, '0},
		'{CMD_SAVE, 48'h5555_5555_5555, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
			1'b0, '0},
		'{CMD_SAVE, 48'h0000_0000_0001, 64'h1, 64'h8000_0000_0000_0000, 1'b0, '0},
		'{CMD_SAVE, 48'h8000_0000_0000, 64'h8000_0000_0000_0000, 64'h1, 1'b0, '0},
		'{CMD_SAVE, 48'h1234_5678_9ABC, 64'h1111_2222_3333_4444, 64'h5555_6666_7777_8888,
			1'b0, '0},
		'{CMD_SAVE, 48'hFEDC_BA98_7654, 64'h9999_AAAA_BBBB_CCCC, 64'hDDDD_EEEE_FFFF_0000,
			1'b0, '0},
		'{CMD_SAVE, 48'h0F0F_0F0F_0F0F, 64'h0F0F_0F0F_0F0F_0F0F, 64'hF0F0_F0F0_F0F0_F0F0,
			1'b0, '0},
		'{CMD_LOOKUP, 48'hFFFF_FFFF_FFFF, 64'h0, 64'h0, 1'b0, '0},
		'{CMD_DELETE, 48'h5555_5555_5555, 64'h0, 64'h0, 1'b0, '0},
		'{CMD_SET_LAST, 48'hFEDC_BA98_7654, 64'h0, 64'h0, 1'b0, '0},
		'{CMD_DELETE, 48'hFEDC_BA98_7654, 64'h0, 64'h0, 1'b0, '0},
		'{CMD_DELETE, 48'hFEDC_BA98_7654, 64'h0, 64'h0, 1'b0, '0},
		'{CMD_DELETE, 48'h5555_5555_5555, 64'h0, 64'h0, 1'b0, '0},
		'{CMD_LOOKUP, 48'h1234_5678_9ABC, 64'h0, 64'h0, 1'b0, '0},
		'{CMD_LOOKUP, 48'hFEDC_BA98_7654, 64'h0, 64'h0, 1'b0, '0},
		'{CMD_SAVE, 48'h1234_5678_9ABC, 64'hC0DE_C0DE_C0DE_C0DE, 64'h0BAD_F00D_0BAD_F00D,
			1'b0, '0},
		'{CMD_LOOKUP, 48'h0, '1, '1, 1'b0, '0},
		'{CMD_DELETE, 48'h0F0F_0F0F_0F0F, 64'h0, 64'h0, 1'b0, '0}
	};

	// ------------------------------------------------------------------
	// Checking: every done cycle is paired with the oldest outstanding item.
	// ------------------------------------------------------------------
	function automatic void log_failure(string what);
		if (fail_count < 10)
			$display("[%0t] %s", $realtime, what);
		fail_count++;
	endfunction

	function automatic void check_field(string name, logic [KEY_W-1:0] want,
			logic [KEY_W-1:0] got);
		if (got !== want)
			log_failure($sformatf("item %0d %s: expected %h, got %h",
				checked, name, want, got));
	endfunction

	always @(posedge clk) begin : result_check
		pairing_result_t want;
		if (arst_n && done === 1'b1) begin
			if (outcomes_due.size() == 0) begin
				log_failure("result strobe with no item outstanding");
			end else begin
				want = outcomes_due.pop_front();
				check_field("hit", KEY_W'(want.hit), KEY_W'(hit));
				check_field("found_key_high", want.key_hi, found_key_high);
				check_field("found_key_low", want.key_lo, found_key_low);
				check_field("last_address", KEY_W'(want.last_addr), KEY_W'(last_address));
				check_field("last_valid", KEY_W'(want.last_valid), KEY_W'(last_valid));
				check_field("paired_count", KEY_W'(want.total), KEY_W'(paired_count));
				checked++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Driving. All inputs change by NBA at the rising edge only, and each
	// input gets at most one NBA per time step.
	// ------------------------------------------------------------------

	// holds the item until the edge that takes it (start high, busy low)
	task automatic send_item(pdks_cmd_t op, logic [ADDR_W-1:0] addr,
			logic [KEY_W-1:0] kh, logic [KEY_W-1:0] kl, bit typed,
			pairing_result_t typed_want);
		pairing_result_t r;
		start          <= 1'b1;
		command        <= op;
		device_address <= addr;
		key_high       <= kh;
		key_low        <= kl;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		r = pairing_outcome(op, addr, kh, kl);
		outcomes_due.push_back(typed ? typed_want : r);
		accepted++;
	endtask

	// sender gap; fields carry junk while start is low
	task automatic idle_gap(int cycles);
		start <= 1'b0;
		repeat (cycles) begin
			command        <= CMD_W'($urandom);
			device_address <= ADDR_W'({$urandom, $urandom});
			key_high       <= {$urandom, $urandom};
			key_low        <= {$urandom, $urandom};
			@(posedge clk);
		end
	endtask

	// start held low until nothing is outstanding, or the limit runs out
	task automatic await_results(int limit);
		int n;
		n = 0;
		start <= 1'b0;
		do begin
			@(posedge clk);
			n++;
		end while (outcomes_due.size() != 0 && n < limit);
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
		logic [ADDR_W-1:0] a;
		logic [KEY_W-1:0]  kh, kl;
		logic [31:0]       r32;
		pdks_cmd_t         op;
		int                w, mode, save_w, lookup_w, delete_w;
		bit                idle_on;

		foreach (paired_addr[i]) begin
			paired_addr[i]   = '0;
			paired_key_hi[i] = '0;
			paired_key_lo[i] = '0;
		end
		paired_total = 0;
		ring_slot    = 0;
		last_conn    = '0;

		// small address pool so saves, lookups and deletes keep colliding;
		// zero and all-ones stay in it for the whole run
		addr_pool[0] = '0;
		addr_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++) begin
			r32 = $urandom;
			addr_pool[i] = {r32[15:0], $urandom};
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[k]) begin
			if ($urandom_range(0, 3) == 0)
				idle_gap($urandom_range(1, 18));
			send_item(directed[k].op, directed[k].addr, directed[k].kh, directed[k].kl,
				directed[k].typed, directed[k].want);
		end
		await_results(1000);

		idle_on = 1'b1;
		save_w = 40; lookup_w = 25; delete_w = 25;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// new segment: pick a bias (fill, drain or mixed), whether the
			// sender idles, and maybe refresh one pool address
			if (n % SEGMENT == 0) begin
				mode = $urandom_range(0, 2);
				case (mode)
				0: begin save_w = 60; lookup_w = 20; delete_w = 12; end
				1: begin save_w = 18; lookup_w = 20; delete_w = 55; end
				default: begin save_w = 35; lookup_w = 30; delete_w = 27; end
				endcase
				idle_on = ($urandom_range(0, 2) != 0);
				if ($urandom_range(0, 2) == 0) begin
					r32 = $urandom;
					addr_pool[$urandom_range(2, POOL_SIZE - 1)] = {r32[15:0], $urandom};
				end
			end
			// at least one full stop mid-run with nothing outstanding
			if (n == RANDOM_ITEMS / 2)
				await_results(1000);

			w = $urandom_range(0, 99);
			if (w < save_w)
				op = CMD_SAVE;
			else if (w < save_w + lookup_w)
				op = CMD_LOOKUP;
			else if (w < save_w + lookup_w + delete_w)
				op = CMD_DELETE;
			else
				op = CMD_SET_LAST;

			if ($urandom_range(0, 99) < 85) begin
				a = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
			end else begin
				r32 = $urandom;
				a = {r32[15:0], $urandom};
			end

			case ($urandom_range(0, 19))
			0: begin kh = '0; kl = '1; end
			1: begin kh = '1; kl = '0; end
			default: begin kh = {$urandom, $urandom}; kl = {$urandom, $urandom}; end
			endcase

			if (idle_on && n < QUIET_FROM && $urandom_range(0, 4) == 0)
				idle_gap($urandom_range(1, 18));
			send_item(op, a, kh, kl, 1'b0, '0);
		end

		await_results(SETTLE * 16);
		// catch any stray strobe after the last one
		repeat (SETTLE) @(posedge clk);
		if (outcomes_due.size() != 0)
			log_failure($sformatf("%0d item(s) never produced a result",
				outcomes_due.size()));

		$display("Ran %0d items (save %0d, lookup %0d, delete %0d, set-last %0d), %0d checked.",
			accepted, n_cmd[CMD_SAVE], n_cmd[CMD_LOOKUP], n_cmd[CMD_DELETE],
			n_cmd[CMD_SET_LAST], checked);
		$display("Lookup hits %0d, save updates %0d, delete hits %0d (stale %0d), ",
			lookup_hits, save_updates, delete_hits, stale_deletes,
			"ring overwrites %0d, drained to empty %0d, peak %0d.",
			ring_overwrites, empty_returns, peak_total);
		if (fail_count == 0)
			$display("** paired_device_key_store: PASSED **");
		else
			$display("** paired_device_key_store: FAILED **");
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin : watchdog
		#2_000_000;
		$display("** paired_device_key_store: FAILED **");
		$finish;
	end

endmodule
